// ----- hdl/layer_normalization_row_assert.svh -----
// Assertion macros shared by the layer normalization row design.
`ifndef LAYER_NORMALIZATION_ROW_ASSERT_SVH
`define LAYER_NORMALIZATION_ROW_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LNR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LNR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lnr_pkg.sv -----
// Constants, codes and state type of the layer normalization row design.
`default_nettype none
package lnr_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

    localparam logic [1:0] CFG_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_MEAN_RECIP = 2'd1;
    localparam logic [1:0] CFG_EPSILON = 2'd2;

    localparam logic [6:0]  CHANNELS_RST   = 7'd64;
    localparam logic [15:0] MEAN_RECIP_RST = 16'd1024;
    localparam logic [15:0] EPSILON_RST    = 16'd1;

    localparam logic KIND_PARAM  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam int SQRT_STEPS = 28;
    localparam int DIV_STEPS  = 40;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_MUL,
        ST_MEAN_SAT,
        ST_VAR,
        ST_VMUL_LO,
        ST_VMUL_HI,
        ST_VAR_ADD,
        ST_SQRT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_EMIT_OUT
    } state_t;

endpackage
`default_nettype wire

// ----- hdl/lnr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lnr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- hdl/layer_normalization_row.sv -----
// Layer normalization over a row of channels, Q8.8 in and out.
// Samples and scale/shift loads are accepted one beat per cycle while the block is idle.
// Once a row of samples is held, the block computes the mean, makes a variance pass
// over the row, scales the variance and takes a 28-step bit-serial square root, then
// emits each channel through the 40-step restoring divider; output back-pressure can stall it.
// rst_n clears control state and the configuration registers; the datapath registers and memories hold no reset value.
`include "layer_normalization_row_assert.svh"
`default_nettype none
module layer_normalization_row (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // From bit 0: channel_index[5:0], sample[15:0], scale[15:0], shift[15:0], 2'b0.
    input  wire logic [55:0] s_tdata,
    // kind: 0 loads scale and shift, 1 is a sample.
    input  wire logic        s_tuser,
    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // From bit 0: normalized[15:0], out_channel[5:0], 2'b0.
    output logic      [23:0] m_tdata,
    // row_end: marks the last beat of a row.
    output logic             m_tlast,
    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    localparam int CH_W  = lnr_pkg::CH_W;
    localparam int CNT_W = lnr_pkg::CNT_W;

    // Configuration registers.
    logic [6:0]  chan_cfg_reg;
    logic [15:0] mean_recip_reg;
    logic [15:0] eps_reg;

    // Control and datapath registers.
    lnr_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic [21:0] row_sum_reg, row_sum_next;
    logic        sum_neg_reg, sum_neg_next;
    logic [37:0] mean_prod_reg, mean_prod_next;
    logic [15:0] mean_reg, mean_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic        rd_valid_reg, rd_valid_next;
    logic        sq_valid_reg, sq_valid_next;
    logic [31:0] sq_reg, sq_next;
    logic [37:0] sumsq_reg, sumsq_next;
    logic [34:0] vlo_reg, vlo_next;
    logic [34:0] vhi_reg, vhi_next;
    logic [55:0] rad_reg, rad_next;
    logic [30:0] rem_reg, rem_next;
    logic [27:0] root_reg, root_next;
    logic [4:0]  sqrt_cnt_reg, sqrt_cnt_next;
    logic [27:0] s_reg, s_next;
    logic        dneg_reg, dneg_next;
    logic [15:0] scale_reg, scale_next;
    logic [15:0] shift_reg, shift_next;
    logic [27:0] div_rem_reg, div_rem_next;
    logic [39:0] quo_reg, quo_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    logic [35:0] plo_reg, plo_next;
    logic [35:0] phi_reg, phi_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] out_norm_reg, out_norm_next;
    logic [CH_W-1:0] out_ch_reg, out_ch_next;
    logic        out_last_reg, out_last_next;

    // Memory ports.
    logic            row_we;
    logic [CH_W-1:0] row_waddr;
    logic [15:0]     row_wdata;
    logic [15:0]     row_rdata;
    logic            par_we;
    logic [CH_W-1:0] par_waddr;
    logic [31:0]     par_wdata;
    logic [31:0]     par_rdata;
    logic [CH_W-1:0] rd_addr;

    // Helper signals.
    logic             in_beat;
    logic [CNT_W-1:0] eff_channels;
    logic [CNT_W-1:0] fill_inc;
    logic [16:0]      diff;
    logic             diff_neg;
    logic [15:0]      diff_mag;
    logic [21:0]      sum_mag;
    logic [21:0]      mean_q;
    logic [53:0]      var_full;
    logic [38:0]      var_eps;
    logic [32:0]      sq_trial;
    logic [32:0]      sq_sub;
    logic [28:0]      div_trial;
    logic [27:0]      root_step;
    logic [15:0]      scale_mag;
    logic [55:0]      prod_mag;
    logic [41:0]      norm_term;
    logic [41:0]      norm_sum;
    logic [15:0]      norm_sat;
    logic             out_load;
    logic             emit_last;
    logic             sqrt_done;

    lnr_ram #(
        .WIDTH(16),
        .DEPTH(lnr_pkg::MAX_CHANNELS)
    ) u_row_ram (
        .clk    (clk),
        .wr_en  (row_we),
        .wr_addr(row_waddr),
        .wr_data(row_wdata),
        .rd_addr(rd_addr),
        .rd_data(row_rdata)
    );

    // Scale in the low half, shift in the high half.
    lnr_ram #(
        .WIDTH(32),
        .DEPTH(lnr_pkg::MAX_CHANNELS)
    ) u_param_ram (
        .clk    (clk),
        .wr_en  (par_we),
        .wr_addr(par_waddr),
        .wr_data(par_wdata),
        .rd_addr(rd_addr),
        .rd_data(par_rdata)
    );

    assign s_tready = (state_reg == lnr_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_ch_reg, out_norm_reg};
    assign m_tlast  = out_last_reg;
    assign rd_addr  = idx_reg[CH_W-1:0];

    // A channel count of zero acts as one; values past the store depth are clipped.
    always_comb
    begin
        if (chan_cfg_reg == 7'd0)
        begin
            eff_channels = CNT_W'(1);
        end
        else if (chan_cfg_reg > 7'(lnr_pkg::MAX_CHANNELS))
        begin
            eff_channels = CNT_W'(lnr_pkg::MAX_CHANNELS);
        end
        else
        begin
            eff_channels = chan_cfg_reg[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cfg_reg   <= lnr_pkg::CHANNELS_RST;
            mean_recip_reg <= lnr_pkg::MEAN_RECIP_RST;
            eps_reg        <= lnr_pkg::EPSILON_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                lnr_pkg::CFG_CHANNELS:   chan_cfg_reg   <= cfg_wdata[6:0];
                lnr_pkg::CFG_MEAN_RECIP: mean_recip_reg <= cfg_wdata;
                lnr_pkg::CFG_EPSILON:    eps_reg        <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // Shared arithmetic: deviation from the mean, variance, root and divider trials, and output scaling.
    always_comb
    begin
        diff      = {row_rdata[15], row_rdata} - {mean_reg[15], mean_reg};
        diff_neg  = diff[16];
        diff_mag  = diff_neg ? 16'(~diff + 17'd1) : diff[15:0];
        sum_mag   = row_sum_reg[21] ? (~row_sum_reg + 22'd1) : row_sum_reg;
        mean_q    = mean_prod_reg[37:16];
        var_full  = {vhi_reg, 19'd0} + {19'd0, vlo_reg};
        var_eps   = {1'b0, var_full[53:16]} + {23'd0, eps_reg};
        sq_trial  = {rem_reg, rad_reg[55:54]};
        sq_sub    = {3'b000, root_reg, 2'b01};
        root_step = (sq_trial >= sq_sub) ? {root_reg[26:0], 1'b1} : {root_reg[26:0], 1'b0};
        div_trial = {div_rem_reg, quo_reg[39]};
        scale_mag = scale_reg[15] ? 16'(~scale_reg + 16'd1) : scale_reg;
        prod_mag  = {phi_reg, 20'd0} + {20'd0, plo_reg};
        norm_term = (dneg_reg ^ scale_reg[15]) ? (~{2'b00, prod_mag[55:16]} + 42'd1)
                                                 : {2'b00, prod_mag[55:16]};
        norm_sum  = norm_term + {{26{shift_reg[15]}}, shift_reg};
        if (norm_sum[41] && !(&norm_sum[40:15]))
        begin
            norm_sat = 16'h8000;
        end
        else if (!norm_sum[41] && (|norm_sum[40:15]))
        begin
            norm_sat = 16'h7FFF;
        end
        else
        begin
            norm_sat = norm_sum[15:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        row_sum_next    = row_sum_reg;
        sum_neg_next    = sum_neg_reg;
        mean_prod_next  = mean_prod_reg;
        mean_next       = mean_reg;
        idx_next        = idx_reg;
        rd_valid_next   = 1'b0;
        sq_valid_next   = 1'b0;
        sq_next         = sq_reg;
        sumsq_next      = sumsq_reg;
        vlo_next        = vlo_reg;
        vhi_next        = vhi_reg;
        rad_next        = rad_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        sqrt_cnt_next   = sqrt_cnt_reg;
        s_next          = s_reg;
        dneg_next       = dneg_reg;
        scale_next      = scale_reg;
        shift_next      = shift_reg;
        div_rem_next    = div_rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_norm_next   = out_norm_reg;
        out_ch_next     = out_ch_reg;
        out_last_next   = out_last_reg;
        row_we          = 1'b0;
        row_waddr       = fill_count_reg[CH_W-1:0];
        row_wdata       = s_tdata[21:6];
        par_we          = 1'b0;
        par_waddr       = s_tdata[5:0];
        par_wdata       = {s_tdata[53:38], s_tdata[37:22]};
        fill_inc        = fill_count_reg + CNT_W'(1);
        out_load        = 1'b0;
        emit_last       = 1'b0;
        sqrt_done       = 1'b0;

        unique case (state_reg)
            lnr_pkg::ST_IDLE:
            begin
                if (in_beat && (s_tuser == lnr_pkg::KIND_PARAM))
                begin
                    par_we = 1'b1;
                end
                else if (in_beat)
                begin
                    row_we          = 1'b1;
                    row_sum_next    = row_sum_reg + {{6{s_tdata[21]}}, s_tdata[21:6]};
                    fill_count_next = fill_inc;
                    if (fill_inc >= eff_channels)
                    begin
                        state_next = lnr_pkg::ST_MEAN_MUL;
                    end
                end
            end

            lnr_pkg::ST_MEAN_MUL:
            begin
                mean_prod_next = sum_mag * mean_recip_reg;
                sum_neg_next   = row_sum_reg[21];
                state_next     = lnr_pkg::ST_MEAN_SAT;
            end

            lnr_pkg::ST_MEAN_SAT:
            begin
                // Truncation toward zero, then saturation to Q8.8.
                if (sum_neg_reg)
                begin
                    mean_next = (mean_q > 22'd32768) ? 16'h8000 : 16'(~mean_q + 22'd1);
                end
                else
                begin
                    mean_next = (mean_q > 22'd32767) ? 16'h7FFF : mean_q[15:0];
                end
                sumsq_next = '0;
                idx_next   = '0;
                state_next = lnr_pkg::ST_VAR;
            end

            lnr_pkg::ST_VAR:
            begin
                // Read, square and accumulate run as a three-stage pipeline.
                if (idx_reg < fill_count_reg)
                begin
                    idx_next      = idx_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                end
                if (rd_valid_reg)
                begin
                    sq_next       = diff_mag * diff_mag;
                    sq_valid_next = 1'b1;
                end
                if (sq_valid_reg)
                begin
                    sumsq_next = sumsq_reg + {6'd0, sq_reg};
                end
                if ((idx_reg == fill_count_reg) && !rd_valid_reg && !sq_valid_reg)
                begin
                    state_next = lnr_pkg::ST_VMUL_LO;
                end
            end

            lnr_pkg::ST_VMUL_LO:
            begin
                vlo_next   = sumsq_reg[18:0] * mean_recip_reg;
                state_next = lnr_pkg::ST_VMUL_HI;
            end

            lnr_pkg::ST_VMUL_HI:
            begin
                vhi_next   = sumsq_reg[37:19] * mean_recip_reg;
                state_next = lnr_pkg::ST_VAR_ADD;
            end

            lnr_pkg::ST_VAR_ADD:
            begin
                rad_next      = {1'b0, var_eps, 16'd0};
                rem_next      = '0;
                root_next     = '0;
                sqrt_cnt_next = '0;
                state_next    = lnr_pkg::ST_SQRT;
            end

            lnr_pkg::ST_SQRT:
            begin
                // One root bit per cycle, two radicand bits shifted in.
                rem_next      = (sq_trial >= sq_sub) ? 31'(sq_trial - sq_sub) : 31'(sq_trial);
                root_next     = root_step;
                rad_next      = {rad_reg[53:0], 2'b00};
                sqrt_cnt_next = sqrt_cnt_reg + 5'd1;
                if (sqrt_cnt_reg == 5'(lnr_pkg::SQRT_STEPS - 1))
                begin
                    sqrt_done  = 1'b1;
                    s_next     = (root_step == 28'd0) ? 28'd1 : root_step;
                    idx_next   = '0;
                    state_next = lnr_pkg::ST_EMIT_RD;
                end
            end

            lnr_pkg::ST_EMIT_RD:
            begin
                state_next = lnr_pkg::ST_EMIT_LD;
            end

            lnr_pkg::ST_EMIT_LD:
            begin
                dneg_next    = diff_neg;
                scale_next   = par_rdata[15:0];
                shift_next   = par_rdata[31:16];
                div_rem_next = '0;
                quo_next     = {diff_mag, 24'd0};
                div_cnt_next = '0;
                state_next   = lnr_pkg::ST_DIV;
            end

            lnr_pkg::ST_DIV:
            begin
                // Restoring division: dividend bits shift out as quotient bits shift in.
                if (div_trial >= {1'b0, s_reg})
                begin
                    div_rem_next = 28'(div_trial - {1'b0, s_reg});
                    quo_next     = {quo_reg[38:0], 1'b1};
                end
                else
                begin
                    div_rem_next = div_trial[27:0];
                    quo_next     = {quo_reg[38:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(lnr_pkg::DIV_STEPS - 1))
                begin
                    state_next = lnr_pkg::ST_MUL_LO;
                end
            end

            lnr_pkg::ST_MUL_LO:
            begin
                plo_next   = quo_reg[19:0] * scale_mag;
                state_next = lnr_pkg::ST_MUL_HI;
            end

            lnr_pkg::ST_MUL_HI:
            begin
                phi_next   = quo_reg[39:20] * scale_mag;
                state_next = lnr_pkg::ST_EMIT_OUT;
            end

            lnr_pkg::ST_EMIT_OUT:
            begin
                emit_last = (idx_reg + CNT_W'(1) == fill_count_reg);
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    out_norm_next = norm_sat;
                    out_ch_next   = idx_reg[CH_W-1:0];
                    out_last_next = emit_last;
                    if (emit_last)
                    begin
                        fill_count_next = '0;
                        row_sum_next    = '0;
                        state_next      = lnr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = lnr_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = lnr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lnr_pkg::ST_IDLE;
            fill_count_reg <= '0;
            row_sum_reg    <= '0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            sq_valid_reg   <= 1'b0;
            sqrt_cnt_reg   <= '0;
            div_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            row_sum_reg    <= row_sum_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            sq_valid_reg   <= sq_valid_next;
            sqrt_cnt_reg   <= sqrt_cnt_next;
            div_cnt_reg    <= div_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_neg_reg   <= sum_neg_next;
        mean_prod_reg <= mean_prod_next;
        mean_reg      <= mean_next;
        sq_reg        <= sq_next;
        sumsq_reg     <= sumsq_next;
        vlo_reg       <= vlo_next;
        vhi_reg       <= vhi_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        s_reg         <= s_next;
        dneg_reg      <= dneg_next;
        scale_reg     <= scale_next;
        shift_reg     <= shift_next;
        div_rem_reg   <= div_rem_next;
        quo_reg       <= quo_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        out_norm_reg  <= out_norm_next;
        out_ch_reg    <= out_ch_next;
        out_last_reg  <= out_last_next;
    end

    `LNR_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1,
        fill_count_reg <= CNT_W'(lnr_pkg::MAX_CHANNELS), "row fill count past store depth")
    `LNR_ASSERT_NOW(a_div_rem, clk, rst_n, state_reg == lnr_pkg::ST_DIV,
        div_rem_reg < s_reg, "divider remainder not below divisor")
    `LNR_ASSERT_NEXT(a_sqrt_nonzero, clk, rst_n, sqrt_done, s_reg != 28'd0,
        "standard deviation is zero after square root")
    `LNR_ASSERT_NEXT(a_row_clear, clk, rst_n, out_load && emit_last,
        (fill_count_reg == '0) && (row_sum_reg == '0) && m_tlast && m_tvalid,
        "row state not cleared after last beat")

endmodule
`default_nettype wire
